### rtl/core/vms_pkg.sv
// ----------------------------------------------------------------------------
// vms_pkg
// shared widths and types of the von mises stress pipeline
// ----------------------------------------------------------------------------
package vms_pkg;

    // fixed field widths
    localparam int OUT_WIDTH    = 48;
    localparam int MU_WIDTH     = 32;
    localparam int LAMBDA_WIDTH = 32;

    // square root operand and partial product slice width
    localparam int RAD_WIDTH    = 2 * OUT_WIDTH;
    localparam int CHUNK_WIDTH  = 32;

    // word handed from the front end to the root array
    typedef struct packed {
        logic                 valid;
        logic                 sat;
        logic [RAD_WIDTH-1:0] rad;
    } t_sq_in;

endpackage

### rtl/core/vms_ifs.sv
// ----------------------------------------------------------------------------
// vms_in_if / vms_out_if
// valid/ready channels carrying gradient words in and stress words out
// ----------------------------------------------------------------------------
interface vms_in_if #(parameter int GW = 32);
    logic                                  valid;
    logic                                  ready;
    logic signed [GW-1:0]                  grad_xx;
    logic signed [GW-1:0]                  grad_xy;
    logic signed [GW-1:0]                  grad_xz;
    logic signed [GW-1:0]                  grad_yx;
    logic signed [GW-1:0]                  grad_yy;
    logic signed [GW-1:0]                  grad_yz;
    logic signed [GW-1:0]                  grad_zx;
    logic signed [GW-1:0]                  grad_zy;
    logic signed [GW-1:0]                  grad_zz;
    logic signed [vms_pkg::LAMBDA_WIDTH-1:0] lame_lambda;
    logic [vms_pkg::MU_WIDTH-1:0]          shear_modulus;

    modport source (
        output valid, grad_xx, grad_xy, grad_xz, grad_yx, grad_yy, grad_yz,
               grad_zx, grad_zy, grad_zz, lame_lambda, shear_modulus,
        input  ready
    );
    modport sink (
        input  valid, grad_xx, grad_xy, grad_xz, grad_yx, grad_yy, grad_yz,
               grad_zx, grad_zy, grad_zz, lame_lambda, shear_modulus,
        output ready
    );
endinterface

interface vms_out_if;
    logic                          valid;
    logic                          ready;
    logic [vms_pkg::OUT_WIDTH-1:0] von_mises_stress;
    logic                          saturated;

    modport source (output valid, von_mises_stress, saturated, input ready);
    modport sink (input valid, von_mises_stress, saturated, output ready);
endinterface

### rtl/core/von_mises_stress_from_gradient.sv
// ----------------------------------------------------------------------------
// von_mises_stress_from_gradient
// von mises stress of one element from its displacement gradient and mu
// ----------------------------------------------------------------------------
// Takes one word per cycle and returns one word per word, in order, through
// 61 register stages: 12 stages to form the deviator quadratic form and
// scale it by mu squared (two 3-stage sliced multipliers), one stage to drop
// fraction bits and detect overflow, and 48 stages in the square root array,
// one root bit per stage; its last stage is the output register. The whole
// pipeline advances together, so while the output word is not taken nothing
// moves and the input is not ready. lame_lambda cancels out of the deviator
// and has no effect on the result.
module von_mises_stress_from_gradient #(
    parameter int FRACTION_BITS  = 24,
    parameter int GRADIENT_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vms_in_if.sink     i_in,
    vms_out_if.source  o_out
);
    logic                                 w_en;
    logic signed [GRADIENT_WIDTH-1:0]     w_grad [9];
    vms_pkg::t_sq_in                      w_sq;

    // advance when the output register is free or being emptied
    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    assign w_grad[0] = i_in.grad_xx;
    assign w_grad[1] = i_in.grad_xy;
    assign w_grad[2] = i_in.grad_xz;
    assign w_grad[3] = i_in.grad_yx;
    assign w_grad[4] = i_in.grad_yy;
    assign w_grad[5] = i_in.grad_yz;
    assign w_grad[6] = i_in.grad_zx;
    assign w_grad[7] = i_in.grad_zy;
    assign w_grad[8] = i_in.grad_zz;

    // quadratic form front end
    vms_quad #(.GW(GRADIENT_WIDTH), .F(FRACTION_BITS)) u_quad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_grad  (w_grad),
        .i_mu    (i_in.shear_modulus),
        .o_sq    (w_sq)
    );

    // root array
    vms_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_sq    (w_sq),
        .o_valid (o_out.valid),
        .o_root  (o_out.von_mises_stress),
        .o_sat   (o_out.saturated)
    );

`ifndef NO_ASSERTIONS
    // a clamped word carries the output maximum
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.saturated |-> o_out.von_mises_stress == '1)
        else $error("saturated word without maximum value");

    // a stall freezes the front end handoff
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_sq))
        else $error("front end moved during stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");
`endif
endmodule

### rtl/core/vms_mul.sv
// ----------------------------------------------------------------------------
// vms_mul
// unsigned multiplier cut into 32x32 slices, three register stages
// ----------------------------------------------------------------------------
module vms_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [WA-1:0]   i_a,
    input  logic [WB-1:0]   i_b,
    output logic [WA+WB-1:0] o_p
);
    localparam int CW = vms_pkg::CHUNK_WIDTH;
    localparam int NA = (WA + CW - 1) / CW;
    localparam int NB = (WB + CW - 1) / CW;
    localparam int RW = NB * CW + CW;
    localparam int PW = NA * CW + NB * CW;

    logic [NA*CW-1:0] a_ext;
    logic [NB*CW-1:0] b_ext;
    logic [2*CW-1:0]  r_pp [NA][NB];
    logic [RW-1:0]    n_row [NA];
    logic [RW-1:0]    r_row [NA];
    logic [PW-1:0]    n_p;
    logic [PW-1:0]    r_p;

    assign a_ext = (NA*CW)'(i_a);
    assign b_ext = (NB*CW)'(i_b);

    // slice products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= a_ext[i*CW +: CW] * b_ext[j*CW +: CW];
                end
            end
        end
    end

    // row sums
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (RW'(r_pp[i][j]) << (CW * j));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row <= n_row;
        end
    end

    // final sum
    always_comb begin
        n_p = '0;
        for (int i = 0; i < NA; i++) begin
            n_p = n_p + (PW'(r_row[i]) << (CW * i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p[WA+WB-1:0];
endmodule

### rtl/core/vms_quad.sv
// ----------------------------------------------------------------------------
// vms_quad
// deviator quadratic form times mu squared, scaled to the root operand
// ----------------------------------------------------------------------------
module vms_quad #(
    parameter int GW = 32,
    parameter int F  = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [GW-1:0]          i_grad [9],
    input  logic [vms_pkg::MU_WIDTH-1:0]  i_mu,
    output vms_pkg::t_sq_in               o_sq
);
    localparam int MW  = GW + 1;
    localparam int SQW = 2 * MW;
    localparam int QW  = 2 * MW + 2;
    localparam int UW  = vms_pkg::MU_WIDTH;
    localparam int PW  = QW + 2 * UW;
    localparam int RDW = vms_pkg::RAD_WIDTH;
    localparam int NV  = 12;

    logic [NV-1:0]         r_v;
    logic signed [MW-1:0]  n_d [6];
    logic signed [MW-1:0]  r_d [6];
    logic [MW-1:0]         r_m [6];
    logic [SQW-1:0]        w_sq [6];
    logic [2*UW-1:0]       w_musq;
    logic [UW-1:0]         r_mu1;
    logic [UW-1:0]         r_mu2;
    logic [QW-1:0]         r_w [6];
    logic [QW-1:0]         r_s3 [3];
    logic [QW-1:0]         r_s2a;
    logic [QW-1:0]         r_s2b;
    logic [QW-1:0]         r_q;
    logic [2*UW-1:0]       r_musq [4];
    logic [PW-1:0]         w_p;
    logic [PW-1:0]         w_sh;
    vms_pkg::t_sq_in       r_sq;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
        end else if (i_en) begin
            r_v   <= {r_v[NV-2:0], i_valid};
        end
    end

    // normal differences and shear sums
    always_comb begin
        n_d[0] = MW'(i_grad[0]) - MW'(i_grad[4]);
        n_d[1] = MW'(i_grad[4]) - MW'(i_grad[8]);
        n_d[2] = MW'(i_grad[8]) - MW'(i_grad[0]);
        n_d[3] = MW'(i_grad[1]) + MW'(i_grad[3]);
        n_d[4] = MW'(i_grad[2]) + MW'(i_grad[6]);
        n_d[5] = MW'(i_grad[5]) + MW'(i_grad[7]);
    end

    // stage 1 and 2: terms, then magnitudes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d   <= n_d;
            r_mu1 <= i_mu;
            r_mu2 <= r_mu1;
            for (int k = 0; k < 6; k++) begin
                r_m[k] <= r_d[k][MW-1] ? $unsigned(-r_d[k]) : $unsigned(r_d[k]);
            end
        end
    end

    // six squares and mu squared
    for (genvar k = 0; k < 6; k++) begin : g_sq
        vms_mul #(.WA(MW), .WB(MW)) u_sq (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_a   (r_m[k]),
            .i_b   (r_m[k]),
            .o_p   (w_sq[k])
        );
    end

    vms_mul #(.WA(UW), .WB(UW)) u_musq (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (r_mu2),
        .i_b   (r_mu2),
        .o_p   (w_musq)
    );

    // weights, then adder tree
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_w[k] <= QW'(w_sq[k]) << 1;
            end
            for (int k = 3; k < 6; k++) begin
                r_w[k] <= QW'(w_sq[k]) + (QW'(w_sq[k]) << 1);
            end
            r_s3[0] <= r_w[0] + r_w[1];
            r_s3[1] <= r_w[2] + r_w[3];
            r_s3[2] <= r_w[4] + r_w[5];
            r_s2a   <= r_s3[0] + r_s3[1];
            r_s2b   <= r_s3[2];
            r_q     <= r_s2a + r_s2b;
            r_musq  <= {w_musq, r_musq[0:2]};
        end
    end

    // quadratic form times mu squared
    vms_mul #(.WA(QW), .WB(2 * UW)) u_qmu (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (r_q),
        .i_b   (r_musq[3]),
        .o_p   (w_p)
    );

    // drop fraction bits, flag an operand whose root overflows the output
    assign w_sh = w_p >> (2 * F);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq.valid <= 1'b0;
        end else if (i_en) begin
            r_sq.valid <= r_v[NV-1];
            r_sq.sat   <= |(w_sh >> RDW);
            r_sq.rad   <= w_sh[RDW-1:0];
        end
    end

    assign o_sq = r_sq;
endmodule

### rtl/core/vms_sqrt.sv
// ----------------------------------------------------------------------------
// vms_sqrt
// restoring integer square root, one root bit per register stage
// ----------------------------------------------------------------------------
module vms_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  vms_pkg::t_sq_in                i_sq,
    output logic                           o_valid,
    output logic [vms_pkg::OUT_WIDTH-1:0]  o_root,
    output logic                           o_sat
);
    localparam int RW  = vms_pkg::OUT_WIDTH;
    localparam int XW  = vms_pkg::RAD_WIDTH;
    localparam int MW  = RW + 2;
    localparam int CMW = RW + 4;

    logic          r_v    [RW];
    logic          r_sat  [RW];
    logic [XW-1:0] r_x    [RW];
    logic [MW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic           pv;
        logic           psat;
        logic [XW-1:0]  px;
        logic [MW-1:0]  prem;
        logic [RW-1:0]  proot;
        logic [CMW-1:0] cur;
        logic [CMW-1:0] trial;
        logic           take;

        if (k == 0) begin : g_first
            assign pv    = i_sq.valid;
            assign psat  = i_sq.sat;
            assign px    = i_sq.rad;
            assign prem  = '0;
            assign proot = '0;
        end else begin : g_next
            assign pv    = r_v[k-1];
            assign psat  = r_sat[k-1];
            assign px    = r_x[k-1];
            assign prem  = r_rem[k-1];
            assign proot = r_root[k-1];
        end

        // bring down two operand bits, try root bit one
        assign cur   = {prem, px[XW-1 -: 2]};
        assign trial = CMW'({proot, 2'b01});
        assign take  = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sat[k]  <= psat;
                r_x[k]    <= px << 2;
                r_rem[k]  <= take ? MW'(cur - trial) : cur[MW-1:0];
                r_root[k] <= {proot[RW-2:0], take};
            end
        end
    end

    // clamp on overflow
    assign o_valid = r_v[RW-1];
    assign o_sat   = r_sat[RW-1];
    assign o_root  = r_sat[RW-1] ? '1 : r_root[RW-1];
endmodule
